### sv/pawg_pkg.sv
// Package: waveform codes, register indexes, defaults and the sine table entry function.
`default_nettype none

package pawg_pkg;

  // Default configuration of the generator
  localparam int unsigned PHASE_FRAC_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_ADDR_BITS_DEF = 10;

  // Width of the fixed external fields
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned SAMPLE_W = 17;
  localparam int unsigned AMP_W    = 15;  // table entries 0..32767

  // Waveform select codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SAWTOOTH = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

  // Config register indexes
  localparam logic CFG_WAVEFORM   = 1'b0;
  localparam logic CFG_PHASE_STEP = 1'b1;

  // pi/2 and 1.0 in Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

  // (a * b) >> 62 for Q2.62 operands, kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Quotient n / d by restoring shift and subtract; d is nonzero
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One quarter-wave entry: round(32767 * sin(pi/2 * i / 2^addr_bits)).
  // Evaluated at elaboration only; Taylor series in Q2.62.
  function automatic logic [AMP_W-1:0] sin_entry(input int unsigned i,
                                                 input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] lo_mask;
    logic [63:0] den;
    lo_mask = (64'd1 << addr_bits) - 64'd1;
    x = (HALF_PI_Q62 >> addr_bits) * 64'(i)
      + (((HALF_PI_Q62 & lo_mask) * 64'(i)) >> addr_bits);
    x2   = mul_q62(x, x);
    term = x;
    s    = x;
    // once a term reaches zero every later term stays zero
    for (int k = 1; k < 40 && term != 64'd0; k++) begin
      den  = 64'((2 * k) * (2 * k + 1));
      term = udiv64(mul_q62(term, x2), den);
      if (k[0]) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    if (s > ONE_Q62) begin
      s = ONE_Q62;
    end
    v = ((s >> 30) * 64'd32767 + (64'd1 << 31)) >> 32;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[AMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/phase_accumulator_waveform_generator_core.sv
// Top level: phase accumulator with sine, sawtooth and triangle output pipeline.
`default_nettype none

//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------
//  input    | in        | in_valid_i / in_stall_o  | restart_i
//  output   | out       | out_valid_o / out_stall_i| sample_o (17 bit signed)
//  config   | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One sample tick per cycle while in_stall_o is low; an input transfer reaches
//  output valid through the phase register, sine ROM read register and output register.
//  The sine ROM's registered read sets the middle stage.
//  Reset clears the phase, the config registers and all stage valid flags.
//  A stalled output holds its sample; earlier stages keep filling until
//  each holds an item, then in_stall_o rises.

module phase_accumulator_waveform_generator_core
  import pawg_pkg::*;
#(
  parameter int unsigned PhaseFracBits    = PHASE_FRAC_BITS_DEF,
  parameter int unsigned SineTableAddrBits = SINE_TABLE_ADDR_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // sample tick input
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic                       restart_i,
  // sample output
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic signed [SAMPLE_W-1:0] sample_o,
  // config write port
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic                       cfg_index_i,
  input  wire logic [STEP_W-1:0]          cfg_data_i
);

  localparam int unsigned AccW   = PhaseFracBits + 1;
  localparam int unsigned RomAw  = SineTableAddrBits + 1;
  localparam int unsigned TblN   = 1 << SineTableAddrBits;
  localparam int unsigned ProdW  = AccW + AMP_W;

  localparam logic [AccW-1:0]  OnePhase = AccW'(1) << PhaseFracBits;
  localparam logic [RomAw-1:0] TblNAddr = RomAw'(1) << SineTableAddrBits;

  typedef logic [AMP_W-1:0] sin_rom_t [TblN+1];

  function automatic sin_rom_t build_rom();
    sin_rom_t r;
    for (int i = 0; i <= TblN; i++) begin
      r[i] = sin_entry(i, SineTableAddrBits);
    end
    return r;
  endfunction

  localparam sin_rom_t SinRom = build_rom();

  // Config registers
  logic [1:0]        waveform_q;
  logic [STEP_W-1:0] phase_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q   <= WAVE_SINE;
      phase_step_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WAVEFORM:   waveform_q   <= cfg_data_i[1:0];
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake: each stage loads when it is empty or its successor moves
  logic v1_q, v2_q, out_valid_q;
  logic rdy_out, rdy2, rdy1, in_xfer;

  assign rdy_out    = !out_valid_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy_out;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_xfer    = in_valid_i && rdy1;

  // Tuning word aligned to the phase fraction
  logic [AccW-1:0] step_w;

  if (PhaseFracBits >= STEP_W) begin : g_step_shl
    assign step_w = AccW'(phase_step_q) << (PhaseFracBits - STEP_W);
  end else begin : g_step_shr
    assign step_w = AccW'(phase_step_q >> (STEP_W - PhaseFracBits));
  end

  // Phase accumulator, modulo 2.0
  logic [AccW-1:0] acc_q, acc_d;

  assign acc_d = (restart_i ? '0 : acc_q) + step_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (in_xfer) begin
      acc_q <= acc_d;
    end
  end

  // Stage 1: phase of this sample
  logic [AccW-1:0] phase1_q;
  logic [1:0]      wave1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      phase1_q <= acc_d;
      wave1_q  <= waveform_q;
    end
  end

  // Quadrant decode, ROM address and triangle fold
  logic [PhaseFracBits-1:0]     frac1;
  logic [1:0]                   quad1;
  logic [SineTableAddrBits-1:0] idx1;
  logic [RomAw-1:0]             rom_addr;
  logic [AccW-1:0]              lin_d;

  assign frac1    = phase1_q[PhaseFracBits-1:0];
  assign quad1    = frac1[PhaseFracBits-1 -: 2];
  assign idx1     = frac1[PhaseFracBits-3 -: SineTableAddrBits];
  assign rom_addr = quad1[0] ? (TblNAddr - {1'b0, idx1}) : {1'b0, idx1};

  always_comb begin
    if (wave1_q == WAVE_TRIANGLE) begin
      // above 1.0 fold back: 2.0 - p, which is -p modulo 2.0
      lin_d = (phase1_q > OnePhase) ? (AccW'(0) - phase1_q) : phase1_q;
    end else begin
      lin_d = {1'b0, frac1};
    end
  end

  // Stage 2: ROM read data, linear ramp value
  logic [AMP_W-1:0] rom_q;
  logic [AccW-1:0]  lin2_q;
  logic             neg2_q;
  logic [1:0]       wave2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      rom_q   <= SinRom[rom_addr];
      lin2_q  <= lin_d;
      neg2_q  <= quad1[1];
      wave2_q <= wave1_q;
    end
  end

  // Scale ramp by 32767 (shift and subtract), pick the waveform
  logic [ProdW-1:0]        prod2;
  logic [AMP_W-1:0]        ramp2;
  logic [SAMPLE_W-1:0]     sine2;
  logic [SAMPLE_W-1:0]     sample_d;

  assign prod2 = {lin2_q, {AMP_W{1'b0}}} - ProdW'(lin2_q);
  assign ramp2 = prod2[PhaseFracBits +: AMP_W];
  assign sine2 = neg2_q ? (SAMPLE_W'(0) - {2'b00, rom_q}) : {2'b00, rom_q};

  always_comb begin
    unique case (wave2_q)
      WAVE_SINE:     sample_d = sine2;
      WAVE_SAWTOOTH: sample_d = {2'b01, ramp2};   // 32768 + ramp
      WAVE_TRIANGLE: sample_d = {2'b01, ramp2};
      default:       sample_d = '0;
    endcase
  end

  // Output register
  logic [SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && v2_q) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = $signed(sample_q);

endmodule

`default_nettype wire
